// ===== rtl/html_entity_decoder_assert.svh =====
// Assertion macros shared by the entity decoder modules.
// Expects clk and arst_n in the scope of every use.
`ifndef HTML_ENTITY_DECODER_ASSERT_SVH
`define HTML_ENTITY_DECODER_ASSERT_SVH

// Same-cycle implication.
`define HED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/hed_pkg.sv =====
// Shared types, entity tables and sizes for the HTML entity decoder.
// No dependencies.
`timescale 1ns / 1ps
package hed_pkg;

	localparam int NUM_ENT        = 6;
	localparam int ENT_MAX_LEN    = 6;
	localparam int STORE_DEPTH    = 5;
	localparam int MAX_EMIT       = 6;
	localparam int EMIT_CNT_W     = $clog2(MAX_EMIT + 1);
	localparam int TOTAL_BITS     = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int COUNT_BITS_MAX = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [7:0] AMP_CHAR = 8'h26;

	// Entity spellings, padded with zero past their length.
	localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_MAX_LEN] = '{
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // &amp;
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // &lt;
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // &gt;
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // &quot;
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // &apos;
		'{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}   // &nbsp;
	};
	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};
	localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  out_last;
		logic [TOTAL_BITS-1:0] entity_total;
	} out_item_t;

	// One front-end transaction: up to MAX_EMIT bytes sent out in order.
	typedef struct packed {
		logic [MAX_EMIT-1:0][7:0] bytes;
		logic [EMIT_CNT_W-1:0]    cnt;
		logic                     last;
		logic [TOTAL_BITS-1:0]    total;
	} cmd_t;

endpackage

// ===== rtl/hed_front.sv =====
// Front end: entity prefix matching, held-back prefix and entity counter.
// Depends on hed_pkg and html_entity_decoder_assert.svh.
`timescale 1ns / 1ps
`include "html_entity_decoder_assert.svh"
module hed_front import hed_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t data,
	output logic     cmd_push,
	output cmd_t     cmd
);

	logic [7:0]            store_q [STORE_DEPTH];
	logic [2:0]            plen_q;
	logic [NUM_ENT-1:0]    mask_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic [NUM_ENT-1:0]    keep;
	logic                  done;
	logic [2:0]            done_idx;
	logic [2:0]            pfx;
	logic                  tail_v;
	logic [7:0]            tail;
	logic                  fresh;
	logic [2:0]            plen_d;
	logic [NUM_ENT-1:0]    mask_d;
	logic [COUNT_BITS-1:0] cnt_d;
	logic                  st_we;
	logic [2:0]            st_idx;
	logic [COUNT_BITS_MAX-1:0] cnt_wide;

	always_comb begin
		keep     = '0;
		done     = 1'b0;
		done_idx = '0;
		for (int k = 0; k < NUM_ENT; k++) begin
			if (mask_q[k] && plen_q < ENT_LEN[k] && ENT_TEXT[k][plen_q] == data.in_byte) begin
				keep[k] = 1'b1;
				if (3'(plen_q + 3'd1) == ENT_LEN[k]) begin
					done     = 1'b1;
					done_idx = 3'(k);
				end
			end
		end
	end

	always_comb begin
		pfx    = '0;
		tail_v = 1'b0;
		tail   = data.in_byte;
		fresh  = 1'b1;
		plen_d = '0;
		mask_d = '0;
		cnt_d  = cnt_q;
		st_we  = 1'b0;
		st_idx = '0;
		if (plen_q != '0) begin
			if (done) begin
				fresh  = 1'b0;
				tail   = ENT_CHAR[done_idx];
				tail_v = 1'b1;
				if (cnt_q != '1) begin
					cnt_d = cnt_q + 1'b1;
				end
			end else if (keep != '0 && plen_q < 3'(STORE_DEPTH)) begin
				fresh = 1'b0;
				if (data.in_last) begin
					// flush the prefix including this byte
					pfx    = plen_q;
					tail_v = 1'b1;
				end else begin
					st_we  = 1'b1;
					st_idx = plen_q;
					plen_d = 3'(plen_q + 3'd1);
					mask_d = keep;
				end
			end else begin
				pfx = plen_q;
			end
		end
		if (fresh) begin
			if (data.in_byte == AMP_CHAR) begin
				if (data.in_last) begin
					tail_v = 1'b1;
				end else begin
					st_we  = 1'b1;
					st_idx = '0;
					plen_d = 3'd1;
					mask_d = '1;
				end
			end else begin
				tail_v = 1'b1;
			end
		end
	end

	always_comb begin
		cmd.bytes = '0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			cmd.bytes[i] = store_q[i];
		end
		cmd.bytes[pfx] = tail;
		cmd.cnt   = EMIT_CNT_W'(pfx + {2'b00, tail_v});
		cmd.last  = data.in_last;
		cnt_wide  = COUNT_BITS_MAX'(cnt_d);
		cmd.total = (cnt_wide > COUNT_BITS_MAX'({TOTAL_BITS{1'b1}})) ? '1
			: cnt_wide[TOTAL_BITS-1:0];
		cmd_push  = accept && cmd.cnt != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			mask_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			plen_q <= data.in_last ? 3'd0 : plen_d;
			mask_q <= data.in_last ? '0 : mask_d;
			cnt_q  <= data.in_last ? '0 : cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && st_we) begin
			store_q[st_idx] <= data.in_byte;
		end
	end

	`HED_ASSERT_NOW(a_pending_has_cand, plen_q != '0, mask_q != '0, "pending prefix without candidates")
	`HED_ASSERT_NOW(a_plen_bound, 1'b1, plen_q <= 3'(STORE_DEPTH), "prefix length beyond store")
	`HED_ASSERT_NEXT(a_last_clears, accept && data.in_last, plen_q == '0 && cnt_q == '0, "state not cleared after end of string")

endmodule

// ===== rtl/hed_queue.sv =====
// Short command queue between the matching front end and the byte sender.
// Depends on hed_pkg.
`timescale 1ns / 1ps
module hed_queue import hed_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic q_empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			if (wr_en && !rd_en) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (rd_en && !wr_en) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== rtl/hed_back.sv =====
// Back end: walks the head command byte by byte into the output register.
// Depends on hed_pkg and html_entity_decoder_assert.svh.
`timescale 1ns / 1ps
`include "html_entity_decoder_assert.svh"
module hed_back import hed_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  logic      head_valid,
	output logic      head_pop,
	output out_item_t result,
	output logic      empty,
	input  logic      pop
);

	logic [EMIT_CNT_W-1:0] idx_q;
	out_item_t             out_q;
	logic                  out_valid_q;
	logic                  load;
	logic                  at_end;

	always_comb begin
		load     = head_valid && (!out_valid_q || pop);
		at_end   = idx_q == EMIT_CNT_W'(head.cnt - 1'b1);
		head_pop = load && at_end;
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? '0 : EMIT_CNT_W'(idx_q + 1'b1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte     <= head.bytes[idx_q];
			out_q.out_last     <= head.last && at_end;
			out_q.entity_total <= head.total;
		end
	end

	`HED_ASSERT_NOW(a_pop_on_load, head_pop, load, "queue popped without a send")
	`HED_ASSERT_NOW(a_partial_holds, idx_q != '0, head_valid, "command left the queue half sent")
	`HED_ASSERT_NOW(a_idx_in_cmd, head_valid, idx_q < head.cnt, "byte index past command length")

endmodule

// ===== rtl/html_entity_decoder.sv =====
// Top level of the streaming HTML named-entity decoder.
// Depends on hed_pkg, hed_front, hed_queue and hed_back.
//
//  channel  | handshake    | payload
//  ---------+--------------+------------------------------------------
//  input    | push / full  | data   : in_byte, in_last
//  result   | empty / pop  | result : out_byte, out_last, entity_total
//
// The front end takes one byte per cycle while full is low; a byte that completes an
// entity or passes through yields one result, a broken prefix or end of string up to six.
// The sender moves one result per cycle while results are popped, so a flush holds the
// sender until all its bytes are sent, and full rises once the two-entry command queue fills.
// With the sender idle, a taken byte goes into the command queue, then into the output register.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps
module html_entity_decoder import hed_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  data,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic accept;
	logic cmd_push;
	cmd_t cmd;
	cmd_t head;
	logic q_full;
	logic q_empty;
	logic head_pop;

	assign full   = q_full;
	assign accept = push && !q_full;

	hed_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data     (data),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	hed_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_cmd  (cmd),
		.q_full  (q_full),
		.rd_en   (head_pop),
		.rd_cmd  (head),
		.q_empty (q_empty)
	);

	hed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.head_pop   (head_pop),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
